FILE: hw/rtl/enigma_rotor_stage_macros.svh
// Assertion macros for the enigma rotor stage.
`ifndef ENIGMA_ROTOR_STAGE_MACROS_SVH
`define ENIGMA_ROTOR_STAGE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define ERS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define ERS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ERS_ASSERT(lbl, prop, msg)
`define ERS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/ers_pkg.sv
// Types, codes and mod-26 helpers shared by the rotor stage modules.
`timescale 1ns / 1ps
`default_nettype none

package ers_pkg;

  localparam int unsigned Letters = 26;

  typedef logic [4:0] letter_t;

  typedef enum logic [1:0] {
    KIND_FWD  = 2'd0,
    KIND_INV  = 2'd1,
    KIND_STEP = 2'd2,
    KIND_LOAD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ROLE_LEFT      = 2'd0,
    ROLE_MIDDLE    = 2'd1,
    ROLE_RIGHT     = 2'd2,
    ROLE_REFLECTOR = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    CFG_WIRING_LOW  = 3'd0,
    CFG_WIRING_MID  = 3'd1,
    CFG_WIRING_HIGH = 3'd2,
    CFG_RING        = 3'd3,
    CFG_NOTCH_FIRST = 3'd4,
    CFG_NOTCH_SEC   = 3'd5,
    CFG_ROLE        = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [Letters-1:0][4:0] wiring;
    letter_t                 ring;
    letter_t                 notch_first;
    letter_t                 notch_second;
    role_e                   role;
  } cfg_t;

  typedef struct packed {
    letter_t letter_out;
    logic    carry;
    logic    double_step_ready;
    logic    not_found;
  } result_t;

  // Reduce a 5-bit value to 0..25.
  function automatic letter_t mod26_small(input logic [4:0] v);
    return (v >= 5'(Letters)) ? v - 5'(Letters) : v;
  endfunction

  // (a + b - c) mod 26, all operands already in 0..25.
  function automatic letter_t add_sub26(input letter_t a, input letter_t b,
                                        input letter_t c);
    logic [6:0] s;
    s = {2'b00, a} + {2'b00, b} + 7'(Letters) - {2'b00, c};
    if (s >= 7'(2 * Letters)) begin
      s = s - 7'(2 * Letters);
    end else if (s >= 7'(Letters)) begin
      s = s - 7'(Letters);
    end
    return s[4:0];
  endfunction

  function automatic logic notch_at(input letter_t n, input letter_t off);
    return (n < 5'(Letters)) && (off == n);
  endfunction

  function automatic logic before_notch(input letter_t n, input letter_t off);
    letter_t prev;
    prev = (n == 5'd0) ? 5'(Letters - 1) : n - 5'd1;
    return (n < 5'(Letters)) && (off == prev);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ers_core.sv
// Combinational rotor datapath: substitution, step and offset load.
`timescale 1ns / 1ps
`default_nettype none

module ers_core (
  input  ers_pkg::cfg_t    cfg_i,
  input  ers_pkg::kind_e   kind_i,
  input  ers_pkg::letter_t letter_i,
  input  logic             double_step_in_i,
  input  ers_pkg::letter_t offset_i,
  output ers_pkg::result_t result_o,
  output ers_pkg::letter_t offset_next_o
);
  import ers_pkg::*;

  letter_t              letter_m;
  letter_t              ring_m;
  letter_t              x;
  letter_t              wire_m [Letters];
  logic [Letters-1:0]   match;
  letter_t              inv_idx;
  logic                 found;
  letter_t              off_inc;
  letter_t              off_next;

  assign letter_m = mod26_small(letter_i);
  assign ring_m   = mod26_small(cfg_i.ring);
  assign x        = add_sub26(letter_m, offset_i, ring_m);
  assign off_inc  = (offset_i == 5'(Letters - 1)) ? 5'd0 : offset_i + 5'd1;

  always_comb begin
    for (int i = 0; i < Letters; i++) begin
      wire_m[i] = mod26_small(cfg_i.wiring[i]);
      match[i]  = (wire_m[i] == x);
    end
  end

  // Lowest matching entry wins.
  always_comb begin
    inv_idx = '0;
    for (int i = Letters - 1; i >= 0; i--) begin
      if (match[i]) begin
        inv_idx = 5'(i);
      end
    end
  end

  assign found = |match;

  always_comb begin
    result_o = '0;
    off_next = offset_i;
    unique case (kind_i)
      KIND_FWD: begin
        result_o.letter_out = add_sub26(wire_m[x], ring_m, offset_i);
      end
      KIND_INV: begin
        result_o.letter_out = found ? add_sub26(inv_idx, ring_m, offset_i) : 5'd0;
        result_o.not_found  = !found;
      end
      KIND_STEP: begin
        off_next       = off_inc;
        result_o.carry = notch_at(cfg_i.notch_first, off_inc) ||
                         notch_at(cfg_i.notch_second, off_inc) ||
                         ((cfg_i.role == ROLE_RIGHT) && double_step_in_i);
      end
      KIND_LOAD: begin
        off_next = letter_m;
      end
    endcase
    result_o.double_step_ready = (cfg_i.role == ROLE_MIDDLE) &&
                                 (before_notch(cfg_i.notch_first, off_next) ||
                                  before_notch(cfg_i.notch_second, off_next));
  end

  assign offset_next_o = off_next;

endmodule

`default_nettype wire

FILE: hw/rtl/enigma_rotor_stage.sv
// Enigma rotor stage: input register, rotor datapath, result register.
//
// Usage: items enter on the in_* channel (kind, letter, double_step_in) and one
// result per item leaves on the out_* channel, both valid/ready. A transaction
// takes place at a rising edge with valid and ready high.
// Configuration registers are written over the cfg_* channel (index, data);
// cfg_ready_o is always high. Write only while no item is in flight.
// An accepted item waits in the input register, then moves into the result register.
// Throughput: one item per cycle while the receiver keeps out_ready_i high; the
// offset register is updated in the same cycle the item moves into the result
// register, so a step or load is seen by the very next item.
// Reset clears the offset, the configuration (second notch reads as absent)
// and both pipeline stages.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_ready_o drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

module enigma_rotor_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  letter_i,
  input  logic        double_step_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  letter_out_o,
  output logic        carry_o,
  output logic        double_step_ready_o,
  output logic        not_found_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [59:0] cfg_data_i
);
  import ers_pkg::*;

  `include "enigma_rotor_stage_macros.svh"

  logic [59:0] wiring_low_q;
  logic [59:0] wiring_mid_q;
  logic [9:0]  wiring_high_q;
  letter_t     ring_q;
  letter_t     notch_first_q;
  letter_t     notch_second_q;
  role_e       role_q;
  cfg_t        cfg;

  logic        s1_valid_q;
  kind_e       s1_kind_q;
  letter_t     s1_letter_q;
  logic        s1_dbl_q;

  logic        out_valid_q;
  result_t     res_q;

  letter_t     offset_q;
  letter_t     offset_d;
  letter_t     core_offset;
  result_t     core_res;
  logic        adv;
  logic        in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiring_low_q   <= '0;
      wiring_mid_q   <= '0;
      wiring_high_q  <= '0;
      ring_q         <= '0;
      notch_first_q  <= '0;
      notch_second_q <= 5'(Letters);
      role_q         <= ROLE_LEFT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIRING_LOW:  wiring_low_q   <= cfg_data_i;
        CFG_WIRING_MID:  wiring_mid_q   <= cfg_data_i;
        CFG_WIRING_HIGH: wiring_high_q  <= cfg_data_i[9:0];
        CFG_RING:        ring_q         <= cfg_data_i[4:0];
        CFG_NOTCH_FIRST: notch_first_q  <= cfg_data_i[4:0];
        CFG_NOTCH_SEC:   notch_second_q <= cfg_data_i[4:0];
        CFG_ROLE:        role_q         <= role_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  assign cfg.wiring       = {wiring_high_q, wiring_mid_q, wiring_low_q};
  assign cfg.ring         = ring_q;
  assign cfg.notch_first  = notch_first_q;
  assign cfg.notch_second = notch_second_q;
  assign cfg.role         = role_q;

  // Stage handshake
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q   <= kind_e'(kind_i);
      s1_letter_q <= letter_i;
      s1_dbl_q    <= double_step_in_i;
    end
  end

  ers_core u_core (
    .cfg_i            (cfg),
    .kind_i           (s1_kind_q),
    .letter_i         (s1_letter_q),
    .double_step_in_i (s1_dbl_q),
    .offset_i         (offset_q),
    .result_o         (core_res),
    .offset_next_o    (core_offset)
  );

  assign offset_d = adv ? core_offset : offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      offset_q <= offset_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign letter_out_o        = res_q.letter_out;
  assign carry_o             = res_q.carry;
  assign double_step_ready_o = res_q.double_step_ready;
  assign not_found_o         = res_q.not_found;

  `ERS_ASSERT(a_offset_range, offset_q < 5'(Letters), "offset out of range")
  `ERS_ASSERT(a_offset_hold, !adv |=> $stable(offset_q), "offset moved without an item")
  `ERS_ASSERT(a_ready_when_empty, !out_valid_q |-> in_ready_o, "input stalled while empty")
  `ERS_ASSERT(a_nf_letter, (out_valid_q && res_q.not_found) |-> (res_q.letter_out == 5'd0),
              "not_found with nonzero letter")

endmodule

`default_nettype wire
